// ===== rtl/core/dual_rate_depth_pixel_filter_unit_macros.svh =====
// Assertion macros for the dual rate depth pixel filter.
`ifndef DUAL_RATE_DEPTH_PIXEL_FILTER_UNIT_MACROS_SVH
`define DUAL_RATE_DEPTH_PIXEL_FILTER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset
`define DRDPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define DRDPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/drdpf_pkg.sv =====
// Shared constants for the dual rate depth pixel filter.
package drdpf_pkg;

  // Parameter defaults
  localparam int MAX_PIXELS_DEF    = 524288;
  localparam int DEPTH_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Register widths
  localparam int FRAME_W = 20;
  localparam int FGAIN_W = 17;
  localparam int SGAIN_W = 16;
  localparam int HYST_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 2'd3;

  // Reset values
  localparam logic [FRAME_W-1:0] FRAME_RST = 20'd307200;
  localparam logic [FGAIN_W-1:0] FGAIN_RST = 17'd58982;
  localparam logic [SGAIN_W-1:0] SGAIN_RST = 16'd6554;
  localparam logic [HYST_W-1:0]  HYST_RST  = 32'd0;

  // Gain format: 16 fraction bits (Q1.16 fast gain, Q0.16 slow gain), one equals 65536
  localparam int GAIN_ONE   = 65536;
  localparam int GAIN_SHIFT = 16;
  localparam int GAIN_HALF  = 32768;

endpackage

// ===== rtl/core/dual_rate_depth_pixel_filter_unit.sv =====
// Dual rate depth pixel filter: per-pixel fast/slow averages with change detect.
//
//  channel   | dir | handshake                  | beat contents
//  ----------+-----+----------------------------+------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready| tdata: depth; tuser: prime
//  m_axis    | out | m_axis_tvalid/m_axis_tready| tdata: filtered_depth; tlast
//  cfg       | in  | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One pixel per cycle unless the output or a position hazard stalls the input.
// Per-pixel state sits in one memory read in the cycle after accept and written
// back at the last stage; a beat whose position is still in flight waits, so
// frames shorter than 11 pixels stall the input.
// A stalled output beat holds the whole pipeline. Reset clears control state
// and registers; the state memory needs no clearing (prime frame seeds it).
`include "dual_rate_depth_pixel_filter_unit_macros.svh"

module dual_rate_depth_pixel_filter_unit #(
  parameter int MAX_PIXELS    = drdpf_pkg::MAX_PIXELS_DEF,
  parameter int DEPTH_BITS    = drdpf_pkg::DEPTH_BITS_DEF,
  parameter int FRACTION_BITS = drdpf_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] depth
  input  logic        s_axis_tuser,   // [0] prime
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] filtered_depth
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [drdpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drdpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drdpf_pkg::*;

  localparam int W   = DEPTH_BITS + FRACTION_BITS;
  localparam int VW  = 2 * DEPTH_BITS + FRACTION_BITS;
  localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW  = ((AW > FRAME_W) ? AW : FRAME_W) + 1;
  localparam int HW  = (FRACTION_BITS >= 16) ? FRACTION_BITS + 16 : 32;
  localparam int HSL = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int HSR = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
  localparam int MW  = (W > HW) ? W : HW;
  localparam int PW  = W + FGAIN_W;
  localparam int VPW = VW + FGAIN_W;
  localparam int NS  = 10;

  typedef struct packed {
    logic [W-1:0]  fast;
    logic [W-1:0]  slow;
    logic [VW-1:0] variance;
    logic [W-1:0]  held;
  } entry_t;

  typedef struct packed {
    logic [W-1:0] x;
    logic         prime;
    logic         zero;
    logic         last;
  } meta_t;

  localparam int EW = $bits(entry_t);

  // Configuration registers
  logic [FRAME_W-1:0] frame_pixels;
  logic [FGAIN_W-1:0] fast_gain;
  logic [SGAIN_W-1:0] slow_gain;
  logic [HYST_W-1:0]  hysteresis_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels     <= FRAME_RST;
      fast_gain        <= FGAIN_RST;
      slow_gain        <= SGAIN_RST;
      hysteresis_level <= HYST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_PIXELS: begin
          if (cfg_data[FRAME_W-1:0] != '0 &&
              32'(cfg_data[FRAME_W-1:0]) <= 32'(MAX_PIXELS))
            frame_pixels <= cfg_data[FRAME_W-1:0];
        end
        REG_FAST_GAIN: begin
          if (cfg_data[FGAIN_W-1:0] != '0 &&
              32'(cfg_data[FGAIN_W-1:0]) <= 32'(GAIN_ONE))
            fast_gain <= cfg_data[FGAIN_W-1:0];
        end
        REG_SLOW_GAIN: begin
          if (cfg_data[SGAIN_W-1:0] != '0)
            slow_gain <= cfg_data[SGAIN_W-1:0];
        end
        REG_HYSTERESIS: hysteresis_level <= cfg_data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic          adv, accept, hazard, dup_wr, wr_en, last_now;
  logic [AW-1:0] pos;
  logic [CW-1:0] pos_inc;
  logic          vld [1:NS];
  logic [AW-1:0] adr [1:NS];
  meta_t         meta [1:NS];
  meta_t         meta_in;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_inc       = CW'(pos) + CW'(1);
  assign last_now      = pos_inc >= CW'(frame_pixels);

  // Stall a beat whose position is still being updated downstream
  always_comb begin
    hazard = 1'b0;
    dup_wr = 1'b0;
    for (int i = 1; i <= NS; i++) begin
      if (vld[i] && adr[i] == pos) hazard = 1'b1;
    end
    for (int i = 1; i < NS; i++) begin
      if (vld[i] && adr[i] == adr[NS]) dup_wr = 1'b1;
    end
  end

  always_comb begin
    meta_in.x     = {s_axis_tdata[DEPTH_BITS-1:0], {FRACTION_BITS{1'b0}}};
    meta_in.prime = s_axis_tuser;
    meta_in.zero  = !s_axis_tuser && s_axis_tdata[DEPTH_BITS-1:0] == '0;
    meta_in.last  = last_now;
  end

  // Pixel position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last_now ? '0 : pos_inc[AW-1:0];
    end
  end

  // Valid bits and carried address/flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[1] <= accept;
      for (int i = 2; i <= NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adr[1]  <= pos;
      meta[1] <= meta_in;
      for (int i = 2; i <= NS; i++) begin
        adr[i]  <= adr[i-1];
        meta[i] <= meta[i-1];
      end
    end
  end

  // State memory
  logic [EW-1:0] mem [MAX_PIXELS];
  logic [EW-1:0] rdata;
  entry_t        rd, wdata;

  always_ff @(posedge clk) begin
    if (wr_en) mem[adr[NS]] <= wdata;
    if (adv) rdata <= mem[pos];
  end
  assign rd = entry_t'(rdata);

  // Stage registers
  logic [W-1:0]   df2, ds2, fold2, sold2;
  logic           fdir2, sdir2;
  logic [PW-1:0]  pf3, ps3;
  logic [W-1:0]   fold3, sold3, d1_3;
  logic           fdir3, sdir3;
  logic [W-1:0]   d1_4, d1_5, d2_5, gap5;
  logic [2*W-1:0] prod6, gsq6;
  logic [VW-1:0]  vd7, gsq7, gsq8, gsq9, var9, varf10;
  logic           vdir7, vdir8;
  logic [VPW-1:0] pv8;
  logic [W-1:0]   slowf10, hd10;
  logic [VW-1:0]  vold [2:8];
  logic [W-1:0]   hold [2:NS];
  logic [W-1:0]   fst [4:NS];
  logic [W-1:0]   slw [4:9];

  // Stage combinational values
  logic [W-1:0]   x1, x3, x4, sf3, ss3, fast3, slow3;
  logic [VW-1:0]  mf6, sv8, var8, slowsel, varsel;
  logic [W-1:0]   slowsel9, hd9;
  logic           snap9;

  assign x1 = meta[1].x;
  assign x3 = meta[3].x;
  assign x4 = meta[4].x;

  // Stage 3: round the gain products, step the averages
  always_comb begin
    sf3   = W'((pf3 + PW'(GAIN_HALF)) >> GAIN_SHIFT);
    ss3   = W'((ps3 + PW'(GAIN_HALF)) >> GAIN_SHIFT);
    fast3 = fdir3 ? fold3 + sf3 : fold3 - sf3;
    slow3 = sdir3 ? sold3 + ss3 : sold3 - ss3;
  end

  // Stage 6: scaled cross product against the old variance
  assign mf6 = VW'(prod6 >> FRACTION_BITS);

  // Stage 8: variance step
  always_comb begin
    sv8  = VW'((pv8 + VPW'(GAIN_HALF)) >> GAIN_SHIFT);
    var8 = vdir8 ? vold[8] + sv8 : vold[8] - sv8;
  end

  // Stage 9: change detect, then distance to held output
  always_comb begin
    snap9    = gsq9 > var9;
    slowsel9 = snap9 ? fst[9] : slw[9];
    slowsel  = '0;
    varsel   = snap9 ? '0 : var9;
    hd9      = (slowsel9 >= hold[9]) ? slowsel9 - hold[9] : hold[9] - slowsel9;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1 -> 2: differences against the stored averages
      fdir2 <= x1 >= rd.fast;
      df2   <= (x1 >= rd.fast) ? x1 - rd.fast : rd.fast - x1;
      sdir2 <= x1 >= rd.slow;
      ds2   <= (x1 >= rd.slow) ? x1 - rd.slow : rd.slow - x1;
      fold2 <= rd.fast;
      sold2 <= rd.slow;
      vold[2] <= rd.variance;
      hold[2] <= rd.held;
      // stage 2 -> 3: gain products
      pf3   <= PW'(df2) * PW'(fast_gain);
      ps3   <= PW'(ds2) * PW'(slow_gain);
      fold3 <= fold2;
      sold3 <= sold2;
      fdir3 <= fdir2;
      sdir3 <= sdir2;
      d1_3  <= ds2;
      // stage 3 -> 4
      fst[4] <= fast3;
      slw[4] <= slow3;
      d1_4   <= d1_3;
      // stage 4 -> 5: second distance and fast-slow gap
      d1_5 <= d1_4;
      d2_5 <= (x4 >= slw[4]) ? x4 - slw[4] : slw[4] - x4;
      gap5 <= (fst[4] >= slw[4]) ? fst[4] - slw[4] : slw[4] - fst[4];
      // stage 5 -> 6: products
      prod6 <= (2*W)'(d1_5) * (2*W)'(d2_5);
      gsq6  <= (2*W)'(gap5) * (2*W)'(gap5);
      // stage 6 -> 7
      vdir7 <= mf6 >= vold[6];
      vd7   <= (mf6 >= vold[6]) ? mf6 - vold[6] : vold[6] - mf6;
      gsq7  <= VW'(gsq6 >> FRACTION_BITS);
      // stage 7 -> 8
      pv8   <= VPW'(vd7) * VPW'(fast_gain);
      vdir8 <= vdir7;
      gsq8  <= gsq7;
      // stage 8 -> 9
      var9 <= var8;
      gsq9 <= gsq8;
      // stage 9 -> 10
      slowf10 <= slowsel9;
      varf10  <= varsel | slowsel;
      hd10    <= hd9;
      for (int i = 3; i <= 8; i++) vold[i] <= vold[i-1];
      for (int i = 3; i <= NS; i++) hold[i] <= hold[i-1];
      for (int i = 5; i <= NS; i++) fst[i] <= fst[i-1];
      for (int i = 5; i <= 9; i++) slw[i] <= slw[i-1];
    end
  end

  // Stage 10: hysteresis, write back, output beat
  logic [HW-1:0] thresh;
  logic [W-1:0]  held_new, result;
  logic          upd;

  assign thresh = (HW'(hysteresis_level) << HSL) >> HSR;
  assign upd    = MW'(hd10) > MW'(thresh);

  always_comb begin
    held_new = upd ? slowf10 : hold[NS];
    if (meta[NS].prime) begin
      wdata.fast     = meta[NS].x;
      wdata.slow     = meta[NS].x;
      wdata.variance = '0;
      wdata.held     = meta[NS].x;
      result         = meta[NS].x;
    end else begin
      wdata.fast     = fst[NS];
      wdata.slow     = slowf10;
      wdata.variance = varf10;
      wdata.held     = held_new;
      result         = meta[NS].zero ? hold[NS] : held_new;
    end
  end

  assign wr_en = adv && vld[NS] && !meta[NS].zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= 32'(result);
      m_axis_tlast <= meta[NS].last;
    end
  end

  // Checks
  `DRDPF_ASSERT(a_no_dup_write, wr_en |-> !dup_wr, "write back with same pixel still in flight")
  `DRDPF_ASSERT(a_last_wraps, (accept && last_now) |=> (pos == '0), "position did not wrap after last pixel")
  `DRDPF_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_axis_tvalid && !vld[1] && !vld[NS]), "pipeline not empty after reset")

endmodule

// ===== bench/tb_dual_rate_depth_pixel_filter_unit.sv =====
// Testbench for the dual rate depth pixel filter: random stream traffic against a predictor.
`timescale 1ns / 100ps

module tb_dual_rate_depth_pixel_filter_unit;
  import drdpf_pkg::*;

  localparam int PIXEL_CAP     = 524288;
  localparam int STALL_LIMIT   = 3000;
  localparam int LATENCY_WAIT  = 24;

  // Per-pixel filter predictor and store of expected output beats
  class depth_filter_scoreboard;
    logic [63:0] fast_mean [int];
    logic [63:0] slow_mean [int];
    logic [63:0] variance [int];
    logic [63:0] held_out [int];
    bit          seeded [int];
    logic [18:0] position;
    logic [63:0] frame_len, gain_fast, gain_slow, hyst_level;
    logic [32:0] expected_beats [$];
    int          errors;
    int          beats_in, beats_out, primes, zeros, snaps;

    function void reset_state();
      frame_len  = 64'(FRAME_RST);
      gain_fast  = 64'(FGAIN_RST);
      gain_slow  = 64'(SGAIN_RST);
      hyst_level = 64'(HYST_RST);
      position   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      logic [63:0] v;
      v = 64'(value);
      case (idx)
        REG_FRAME_PIXELS: begin
          v = v & 64'hFFFFF;
          if (v >= 1 && v <= PIXEL_CAP) frame_len = v;
        end
        REG_FAST_GAIN: begin
          v = v & 64'h1FFFF;
          if (v >= 1 && v <= GAIN_ONE) gain_fast = v;
        end
        REG_SLOW_GAIN: begin
          v = v & 64'hFFFF;
          if (v != 0) gain_slow = v;
        end
        REG_HYSTERESIS: hyst_level = v & 64'hFFFF_FFFF;
        default: ;
      endcase
    endfunction

    // d * g / 65536, rounded half up
    function logic [63:0] scale_gain(logic [63:0] d, logic [63:0] g);
      return (d >> 16) * g + (((d & 64'hFFFF) * g + GAIN_HALF) >> 16);
    endfunction

    function logic [63:0] ema(logic [63:0] old, logic [63:0] x, logic [63:0] g);
      if (x >= old) return old + scale_gain(x - old, g);
      return old - scale_gain(old - x, g);
    endfunction

    // (a * b) >> 16, exact floor
    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      return (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
    endfunction

    function logic [63:0] gap_of(logic [63:0] a, logic [63:0] b);
      return a >= b ? a - b : b - a;
    endfunction

    function bit is_seeded(int p);
      return seeded.exists(p);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Accepted input beat: advance the per-pixel state, queue the expected output
    function void note_input(logic [15:0] depth, bit prime);
      logic [63:0] x, fast, slow_old, slow, var_new, gap, result;
      int p;
      bit last;
      x = 64'(depth) << 16;
      p = int'(position);
      beats_in++;
      if (prime) begin
        fast_mean[p] = x;
        slow_mean[p] = x;
        variance[p]  = '0;
        held_out[p]  = x;
        seeded[p]    = 1'b1;
        result = x;
        primes++;
      end else if (x != 0) begin
        fast     = ema(fast_mean[p], x, gain_fast);
        slow_old = slow_mean[p];
        slow     = ema(slow_old, x, gain_slow);
        var_new  = ema(variance[p],
                       frac_mul(gap_of(x, slow_old), gap_of(x, slow)), gain_fast);
        gap = gap_of(fast, slow);
        if (frac_mul(gap, gap) > var_new) begin
          slow = fast;
          var_new = '0;
          snaps++;
        end
        fast_mean[p] = fast;
        slow_mean[p] = slow;
        variance[p]  = var_new;
        if (gap_of(slow, held_out[p]) > hyst_level) held_out[p] = slow;
        result = held_out[p];
      end else begin
        result = held_out[p];
        zeros++;
      end
      last = (64'(position) + 1 >= frame_len);
      position = last ? 19'd0 : position + 19'd1;
      expected_beats.push_back({last, result[31:0]});
    endfunction

    function void check_result(logic [31:0] data, logic last);
      logic [32:0] want;
      beats_out++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected output beat: data %h last %b", $time, data, last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want[31:0]) begin
        $display("%0t: filtered_depth mismatch: expected %h, actual %h",
                 $time, want[31:0], data);
        errors++;
      end
      if (last !== want[32]) begin
        $display("%0t: tlast mismatch: expected %b, actual %b", $time, want[32], last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [15:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [31:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  depth_filter_scoreboard sb = new();
  int  tx_mode, rx_mode;
  bit  rx_hold_req;
  int  quiet_cycles;
  logic [15:0] pixel_base [int];
  int  noise_span;

  always #4 clk = ~clk;

  dual_rate_depth_pixel_filter_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int idle_draw(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 17);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  // Send one pixel beat; valid stays high across back-to-back beats
  task automatic send_pixel(logic [15:0] depth, bit prime);
    int gap;
    gap = idle_draw(tx_mode);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= depth;
    s_axis_tuser  <= prime;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(depth, prime);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // Register write; only issued once the pipeline is empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // One pixel of a mostly well-formed stream: steady depth plus noise per position
  task automatic send_random_pixel();
    int p, r, v;
    logic [15:0] d;
    p = int'(sb.position);
    if (!pixel_base.exists(p)) pixel_base[p] = $urandom_range(1, 65535);
    r = $urandom_range(0, 99);
    if (!sb.is_seeded(p) || r < 3) begin
      d = ($urandom_range(0, 9) == 0) ? 16'd0 : pixel_base[p];
      send_pixel(d, 1'b1);
    end else if (r < 10) begin
      send_pixel(16'd0, 1'b0);
    end else if (r < 18) begin
      send_pixel(16'($urandom()), 1'b0);
    end else if (r < 25) begin
      pixel_base[p] = $urandom_range(1, 65535);
      send_pixel(pixel_base[p], 1'b0);
    end else begin
      v = int'(pixel_base[p]) + $urandom_range(0, 2 * noise_span) - noise_span;
      if (v < 1) v = 1;
      if (v > 65535) v = 65535;
      send_pixel(16'(v), 1'b0);
    end
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    int wait_n;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      wait_n = idle_draw(rx_mode);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_dual_rate_depth_pixel_filter_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] prime_set [8];
    logic [15:0] live_set [8];
    int frame_pick [10];
    logic [31:0] value;

    prime_set = '{16'd0, 16'hFFFF, 16'd1, 16'h8000,
                  16'hAAAA, 16'h5555, 16'd100, 16'd200};
    live_set  = '{16'd0, 16'd0, 16'd1, 16'h8001,
                  16'h5555, 16'hAAAA, 16'hFFFF, 16'd300};
    frame_pick = '{1, 2, 3, 4, 7, 11, 12, 40, 97, 256};
    quiet_cycles = 0;
    rx_hold_req = 1'b0;
    tx_mode = 0;
    rx_mode = 0;
    noise_span = 64;
    sb.reset_state();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FRAME_PIXELS;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: out-of-range writes are dropped, then extreme gains
    write_reg(REG_FRAME_PIXELS, 32'd0);
    write_reg(REG_FRAME_PIXELS, 32'd524289);
    write_reg(REG_FAST_GAIN, 32'd0);
    write_reg(REG_FAST_GAIN, 32'd65537);
    write_reg(REG_SLOW_GAIN, 32'h0001_0000);
    write_reg(REG_FRAME_PIXELS, 32'd8);
    write_reg(REG_FAST_GAIN, 32'd65536);
    write_reg(REG_SLOW_GAIN, 32'd1);
    write_reg(REG_HYSTERESIS, 32'd0);
    foreach (prime_set[i]) send_pixel(prime_set[i], 1'b1);
    foreach (live_set[i]) send_pixel(live_set[i], 1'b0);
    drain_results();
    // slow gain above fast gain is still taken; large hysteresis holds output
    write_reg(REG_FAST_GAIN, 32'd1);
    write_reg(REG_SLOW_GAIN, 32'd65535);
    write_reg(REG_HYSTERESIS, 32'h0001_0000);
    foreach (live_set[i]) send_pixel(~live_set[i], 1'b0);
    drain_results();

    // Longest frame: only a few pixels, then a shorter frame forces the wrap
    write_reg(REG_FRAME_PIXELS, 32'd524288);
    write_reg(REG_HYSTERESIS, 32'hFFFF_FFFF);
    repeat (30) send_random_pixel();
    drain_results();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_FRAME_PIXELS, 32'(frame_pick[$urandom_range(0, 9)]));
      case ($urandom_range(0, 2))
        0: value = 32'd1;
        1: value = 32'd65536;
        default: value = $urandom_range(1, 65536);
      endcase
      write_reg(REG_FAST_GAIN, value);
      case ($urandom_range(0, 2))
        0: value = 32'd1;
        1: value = 32'd65535;
        default: value = $urandom_range(1, 65535);
      endcase
      write_reg(REG_SLOW_GAIN, value);
      case ($urandom_range(0, 3))
        0: value = 32'd0;
        1: value = 32'hFFFF_FFFF;
        2: value = $urandom_range(0, 1 << 20);
        default: value = $urandom();
      endcase
      write_reg(REG_HYSTERESIS, value);
      tx_mode = (ph % 3 == 0) ? 0 : $urandom_range(0, 2);
      rx_mode = (ph % 3 == 1) ? 0 : $urandom_range(0, 2);
      noise_span = 1 << $urandom_range(0, 12);
      if (ph == 2) begin
        tx_mode = 0;
        rx_hold_req = 1'b1;
      end
      for (int n = 0; n < 110; n++) begin
        if (ph == 5 && n == 50) begin
          // sender pause until the pipeline has emptied
          s_axis_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_random_pixel();
      end
      drain_results();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;

    $display("Run covered %0d pixels in, %0d beats out: %0d primes, %0d zero samples,",
             sb.beats_in, sb.beats_out, sb.primes, sb.zeros);
    $display("%0d slow-average snaps, several frame lengths, gains and hysteresis levels.",
             sb.snaps);
    if (sb.errors == 0) begin
      $display("tb_dual_rate_depth_pixel_filter_unit: done, clean");
    end else begin
      $display("tb_dual_rate_depth_pixel_filter_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== dual_rate_depth_pixel_filter_unit.f =====
+incdir+rtl/core
rtl/core/drdpf_pkg.sv
rtl/core/dual_rate_depth_pixel_filter_unit.sv
bench/tb_dual_rate_depth_pixel_filter_unit.sv
